>>> design/sfd_pkg.sv
// types and constants shared by the stx/etx deframer
package sfd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KIND_W = 3;
    localparam int unsigned LEN_W  = 16;

    localparam logic [BYTE_W-1:0] STX_BYTE  = 8'h02;
    localparam logic [BYTE_W-1:0] NUL_BYTE  = 8'h00;
    localparam logic [BYTE_W-1:0] ETX_BYTE  = 8'h03;
    localparam logic [BYTE_W-1:0] LEN_LONG  = 8'h80;
    localparam logic [BYTE_W-1:0] LEN_EXT1  = 8'h81;
    localparam logic [BYTE_W-1:0] LEN_EXT2  = 8'h82;

    // header (start, reserved, instruction) plus footer (lrc, etx)
    localparam logic [2:0] FRAME_OVERHEAD = 3'd5;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_LENX = 2'd2,
        PH_BODY = 2'd3
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        K_DATA  = 3'd0,
        K_GOOD  = 3'd1,
        K_LRC   = 3'd2,
        K_ETX   = 3'd3,
        K_SHORT = 3'd4
    } t_kind;

endpackage

>>> design/stx_frame_deframer_lrc.sv
// stx/etx frame deframer with xor lrc check
//
// Input channel: one received byte per request (i_valid / o_ready, i_rx_byte).
// Output channel: zero or one result per input byte (o_valid / i_ready):
// o_kind data byte or verdict, o_instruction of the current frame,
// o_data_byte payload (zero on a verdict), o_last high on the verdict.
// Each input byte is decoded in the cycle it is accepted and its result
// appears on the output register in the following cycle. One byte per
// cycle is sustained while results are taken; the only state carried
// between bytes is the frame decoder (phase, length, position, lrc),
// updated once per accepted byte. Data bytes leave as they arrive; the
// closing verdict says good, lrc mismatch, etx missing or frame too short,
// and downstream drops the data of a bad frame.
// Reset (synchronous, active low) returns the decoder to hunting for a
// start byte and empties the output register.
// When the receiver stalls, the held result stays on the output and o_ready
// drops until it is taken; a new byte is accepted in the same cycle the held
// result is taken.
module stx_frame_deframer_lrc (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [sfd_pkg::BYTE_W-1:0]  i_rx_byte,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [sfd_pkg::KIND_W-1:0]  o_kind,
    output logic [sfd_pkg::BYTE_W-1:0]  o_instruction,
    output logic [sfd_pkg::BYTE_W-1:0]  o_data_byte,
    output logic                        o_last
);
    import sfd_pkg::*;

    t_phase             r_phase,    n_phase;
    logic               r_stx,      n_stx;
    logic [1:0]         r_form,     n_form;
    logic [LEN_W-1:0]   r_flen,     n_flen;
    logic [LEN_W-1:0]   r_pos,      n_pos;
    logic [BYTE_W-1:0]  r_lrc,      n_lrc;
    logic [BYTE_W-1:0]  r_instr,    n_instr;
    logic               r_lrc_ok,   n_lrc_ok;

    logic               r_out_valid;
    t_kind              r_kind;
    logic [BYTE_W-1:0]  r_out_instr;
    logic [BYTE_W-1:0]  r_out_data;
    logic               r_out_last;

    logic               accept;
    logic               res_valid;
    t_kind              res_kind;
    logic [BYTE_W-1:0]  res_data;
    logic               res_last;
    logic [LEN_W:0]     pos_ext;
    logic [LEN_W:0]     flen_ext;
    logic [LEN_W:0]     min_len;
    logic [LEN_W-1:0]   pos_inc;
    logic [LEN_W:0]     form_p1;
    logic [LEN_W:0]     form_p2;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_phase   = r_phase;
        n_stx     = r_stx;
        n_form    = r_form;
        n_flen    = r_flen;
        n_pos     = r_pos;
        n_lrc     = r_lrc;
        n_instr   = r_instr;
        n_lrc_ok  = r_lrc_ok;
        res_valid = 1'b0;
        res_kind  = K_DATA;
        res_data  = '0;
        res_last  = 1'b0;

        pos_ext  = {1'b0, r_pos};
        flen_ext = {1'b0, r_flen};
        pos_inc  = r_pos + LEN_W'(1);
        form_p1  = (LEN_W+1)'(r_form) + (LEN_W+1)'(1);
        form_p2  = (LEN_W+1)'(r_form) + (LEN_W+1)'(2);
        min_len  = (LEN_W+1)'(r_form) + (LEN_W+1)'(FRAME_OVERHEAD);

        case (r_phase)
            PH_LEN: begin
                if (i_rx_byte < LEN_LONG || i_rx_byte == LEN_EXT1
                        || i_rx_byte == LEN_EXT2) begin
                    n_lrc = r_lrc ^ i_rx_byte;
                    n_pos = LEN_W'(2);
                    if (i_rx_byte < LEN_LONG) begin
                        n_form = 2'd1;
                        n_flen = LEN_W'(i_rx_byte);
                        // short form: length known now
                        if ((LEN_W+1)'(i_rx_byte) < (LEN_W+1)'(3'd1 + FRAME_OVERHEAD)) begin
                            res_valid = 1'b1;
                            res_kind  = K_SHORT;
                            res_last  = 1'b1;
                            n_phase   = PH_HUNT;
                        end else begin
                            n_phase = PH_BODY;
                        end
                    end else begin
                        n_form  = (i_rx_byte == LEN_EXT1) ? 2'd2 : 2'd3;
                        n_flen  = '0;
                        n_phase = PH_LENX;
                    end
                end else if (i_rx_byte == STX_BYTE || i_rx_byte == NUL_BYTE) begin
                    // bad length byte, re-examined as a start byte
                    n_phase  = PH_LEN;
                    n_stx    = (i_rx_byte == STX_BYTE);
                    n_lrc    = i_rx_byte;
                    n_pos    = LEN_W'(1);
                    n_flen   = '0;
                    n_form   = 2'd0;
                    n_instr  = '0;
                    n_lrc_ok = 1'b0;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_LENX: begin
                n_flen = {r_flen[LEN_W-BYTE_W-1:0], i_rx_byte};
                n_lrc  = r_lrc ^ i_rx_byte;
                n_pos  = pos_inc;
                if ({1'b0, pos_inc} >= form_p1) begin
                    if ({1'b0, r_flen[LEN_W-BYTE_W-1:0], i_rx_byte} < min_len) begin
                        res_valid = 1'b1;
                        res_kind  = K_SHORT;
                        res_last  = 1'b1;
                        n_phase   = PH_HUNT;
                    end else begin
                        n_phase = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                n_pos = pos_inc;
                if (pos_ext + (LEN_W+1)'(1) >= flen_ext) begin
                    res_valid = 1'b1;
                    res_last  = 1'b1;
                    n_phase   = PH_HUNT;
                    if (i_rx_byte != ETX_BYTE) begin
                        res_kind = K_ETX;
                    end else if (r_stx && !r_lrc_ok) begin
                        res_kind = K_LRC;
                    end else begin
                        res_kind = K_GOOD;
                    end
                end else if (pos_ext + (LEN_W+1)'(2) == flen_ext) begin
                    // lrc byte: compare against everything before it
                    n_lrc_ok = (r_lrc == i_rx_byte);
                    n_lrc    = r_lrc ^ i_rx_byte;
                end else begin
                    n_lrc = r_lrc ^ i_rx_byte;
                    if (pos_ext == form_p2) begin
                        n_instr = i_rx_byte;
                    end else if (pos_ext != form_p1) begin
                        res_valid = 1'b1;
                        res_kind  = K_DATA;
                        res_data  = i_rx_byte;
                    end
                end
            end
            default: begin
                if (i_rx_byte == STX_BYTE || i_rx_byte == NUL_BYTE) begin
                    n_phase  = PH_LEN;
                    n_stx    = (i_rx_byte == STX_BYTE);
                    n_lrc    = i_rx_byte;
                    n_pos    = LEN_W'(1);
                    n_flen   = '0;
                    n_form   = 2'd0;
                    n_instr  = '0;
                    n_lrc_ok = 1'b0;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_stx       <= 1'b0;
            r_form      <= '0;
            r_flen      <= '0;
            r_pos       <= '0;
            r_lrc       <= '0;
            r_instr     <= '0;
            r_lrc_ok    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_stx       <= n_stx;
                r_form      <= n_form;
                r_flen      <= n_flen;
                r_pos       <= n_pos;
                r_lrc       <= n_lrc;
                r_instr     <= n_instr;
                r_lrc_ok    <= n_lrc_ok;
                r_out_valid <= res_valid;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded only when a new result is produced
    always_ff @(posedge i_clk) begin
        if (accept && res_valid) begin
            r_kind      <= res_kind;
            r_out_instr <= n_instr;
            r_out_data  <= res_data;
            r_out_last  <= res_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_kind        = r_kind;
    assign o_instruction = r_out_instr;
    assign o_data_byte   = r_out_data;
    assign o_last        = r_out_last;

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the stx/etx frame deframer with lrc check
`timescale 1ns / 100ps

module tb_top;
    import sfd_pkg::*;

    localparam int ITEMS       = 1400;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 300;

    typedef enum int {
        FAULT_NONE,
        FAULT_LRC,
        FAULT_ETX,
        FAULT_SHORT,
        FAULT_BADLEN
    } t_frame_fault;

    typedef struct packed {
        t_kind              kind;
        logic [BYTE_W-1:0]  instruction;
        logic [BYTE_W-1:0]  data_byte;
        logic               last;
    } t_deframe_result;

    // tracks the frame decoder and holds the results it still owes
    class t_frame_tracker;
        t_phase             phase;
        logic               is_stx;
        logic [1:0]         len_bytes;
        logic [LEN_W-1:0]   frame_len;
        logic [LEN_W-1:0]   position;
        logic [BYTE_W-1:0]  lrc;
        logic [BYTE_W-1:0]  instruction;
        logic               lrc_ok;
        t_deframe_result    pending_results[$];
        int                 mismatches;

        function new();
            phase       = PH_HUNT;
            is_stx      = 1'b0;
            len_bytes   = '0;
            frame_len   = '0;
            position    = '0;
            lrc         = '0;
            instruction = '0;
            lrc_ok      = 1'b0;
            mismatches  = 0;
        endfunction

        function void push_result(t_kind kind, logic [BYTE_W-1:0] data, logic last);
            t_deframe_result r;
            r.kind        = kind;
            r.instruction = instruction;
            r.data_byte   = data;
            r.last        = last;
            pending_results.push_back(r);
        endfunction

        function void restart_hunt(logic [BYTE_W-1:0] b);
            if (b inside {STX_BYTE, NUL_BYTE}) begin
                phase       = PH_LEN;
                is_stx      = (b == STX_BYTE);
                lrc         = b;
                position    = 16'd1;
                frame_len   = '0;
                len_bytes   = '0;
                instruction = '0;
                lrc_ok      = 1'b0;
            end else begin
                phase = PH_HUNT;
            end
        endfunction

        function void close_length();
            if (frame_len < len_bytes + FRAME_OVERHEAD) begin
                push_result(K_SHORT, '0, 1'b1);
                phase = PH_HUNT;
            end else begin
                phase = PH_BODY;
            end
        endfunction

        function void take_request(logic [BYTE_W-1:0] b);
            int unsigned p;
            case (phase)
                PH_LEN: begin
                    if (b < LEN_LONG) begin
                        len_bytes = 2'd1;
                        frame_len = {8'h00, b};
                    end else if (b == LEN_EXT1) begin
                        len_bytes = 2'd2;
                        frame_len = '0;
                    end else if (b == LEN_EXT2) begin
                        len_bytes = 2'd3;
                        frame_len = '0;
                    end else begin
                        // bad length byte: drop the start and look at this byte again
                        restart_hunt(b);
                        return;
                    end
                    lrc      = lrc ^ b;
                    position = 16'd2;
                    if (len_bytes == 2'd1)
                        close_length();
                    else
                        phase = PH_LENX;
                end
                PH_LENX: begin
                    frame_len = {frame_len[7:0], b};
                    lrc       = lrc ^ b;
                    position  = position + 16'd1;
                    if (position >= len_bytes + 16'd1)
                        close_length();
                end
                PH_BODY: begin
                    p        = position;
                    position = position + 16'd1;
                    if (p + 1 >= frame_len) begin
                        // missing etx wins over a bad lrc
                        if (b != ETX_BYTE)
                            push_result(K_ETX, '0, 1'b1);
                        else if (is_stx && !lrc_ok)
                            push_result(K_LRC, '0, 1'b1);
                        else
                            push_result(K_GOOD, '0, 1'b1);
                        phase = PH_HUNT;
                    end else if (p + 2 == frame_len) begin
                        lrc_ok = (lrc == b);
                        lrc    = lrc ^ b;
                    end else begin
                        lrc = lrc ^ b;
                        if (p == len_bytes + 1) begin
                            // reserved byte
                        end else if (p == len_bytes + 2) begin
                            instruction = b;
                        end else begin
                            push_result(K_DATA, b, 1'b0);
                        end
                    end
                end
                default: restart_hunt(b);
            endcase
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch: %s", $realtime, what);
        endfunction

        function void check_result(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] instr,
                                   logic [BYTE_W-1:0] data, logic last);
            t_deframe_result want;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result kind %0d instr %02h data %02h last %0b",
                                 kind, instr, data, last));
                return;
            end
            want = pending_results.pop_front();
            if (kind !== want.kind || instr !== want.instruction ||
                data !== want.data_byte || last !== want.last)
                report($sformatf("kind %0d/%0d instr %02h/%02h data %02h/%02h last %0b/%0b",
                                 want.kind, kind, want.instruction, instr,
                                 want.data_byte, data, want.last, last));
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [BYTE_W-1:0]   i_rx_byte;
    logic                o_valid;
    logic                i_ready;
    logic [KIND_W-1:0]   o_kind;
    logic [BYTE_W-1:0]   o_instruction;
    logic [BYTE_W-1:0]   o_data_byte;
    logic                o_last;

    t_frame_tracker      frames;
    logic [BYTE_W-1:0]   rx_stream[$];
    int                  cycle_count;
    int                  n_accepted;
    bit                  draining;

    stx_frame_deframer_lrc dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_rx_byte     (i_rx_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_instruction (o_instruction),
        .o_data_byte   (o_data_byte),
        .o_last        (o_last)
    );

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_ready     = 1'b0;
        i_rx_byte   = '0;
        cycle_count = 0;
        n_accepted  = 0;
        draining    = 1'b0;
        frames      = new();
    end

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, and quiet stretches with none
    function automatic int idle_cycles(int long_max);
        int r;
        if ((cycle_count / 1500) % 4 == 1)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, long_max);
    endfunction

    function automatic void push_frame(logic [BYTE_W-1:0] start, int form, int n_data,
                                       t_frame_fault fault);
        logic [BYTE_W-1:0] body[$];
        logic [LEN_W-1:0]  flen;
        logic [BYTE_W-1:0] lrc;
        int                v;
        flen = LEN_W'(form + 5 + n_data);
        if (fault == FAULT_SHORT)
            flen = LEN_W'($urandom_range(0, form + 4));
        body.push_back(start);
        if (fault == FAULT_BADLEN) begin
            v = $urandom_range(0, 125);
            body.push_back(v == 0 ? LEN_LONG : BYTE_W'(8'h82 + v));
        end else if (form == 1) begin
            body.push_back(flen[7:0]);
        end else if (form == 2) begin
            body.push_back(LEN_EXT1);
            body.push_back(flen[7:0]);
        end else begin
            body.push_back(LEN_EXT2);
            body.push_back(flen[15:8]);
            body.push_back(flen[7:0]);
        end
        repeat (n_data + 2) body.push_back(BYTE_W'($urandom_range(0, 255)));
        lrc = '0;
        foreach (body[i]) lrc = lrc ^ body[i];
        if (fault == FAULT_LRC)
            lrc = lrc ^ BYTE_W'($urandom_range(1, 255));
        body.push_back(lrc);
        if (fault == FAULT_ETX) begin
            v = $urandom_range(0, 254);
            body.push_back(BYTE_W'(v >= 3 ? v + 1 : v));
        end else begin
            body.push_back(ETX_BYTE);
        end
        foreach (body[i]) rx_stream.push_back(body[i]);
    endfunction

    task automatic send_request(logic [BYTE_W-1:0] b);
        int gap;
        gap = idle_cycles(30);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        frames.take_request(b);
        n_accepted++;
    endtask

    // receiver: random stalls plus one long hold-off so the input backs up
    initial begin
        int  hold_left;
        int  gap;
        bit  held_once;
        hold_left = 0;
        held_once = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready)
                frames.check_result(o_kind, o_instruction, o_data_byte, o_last);
            if (draining) begin
                i_ready <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (!held_once && n_accepted >= HOLD_AT) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                i_ready <= 1'b0;
            end else begin
                gap = idle_cycles(40);
                if (gap > 0) begin
                    hold_left = gap - 1;
                    i_ready <= 1'b0;
                end else begin
                    i_ready <= 1'b1;
                end
            end
        end
    end

    initial begin
        int           pick;
        int           form;
        int           n_data;
        int           max_data;
        logic [7:0]   start;
        t_frame_fault fault;

        // nul start skips the lrc check, so a bad lrc still gives good
        push_frame(NUL_BYTE, 1, 0, FAULT_LRC);
        // good frame carrying the all-ones data byte with instruction zero
        rx_stream.push_back(STX_BYTE);
        rx_stream.push_back(8'h07);
        rx_stream.push_back(8'h00);
        rx_stream.push_back(8'h00);
        rx_stream.push_back(8'hFF);
        rx_stream.push_back(8'hFA);
        rx_stream.push_back(ETX_BYTE);
        // bad length byte, then too-short lengths in all three forms
        rx_stream.push_back(STX_BYTE);
        rx_stream.push_back(8'h83);
        rx_stream.push_back(STX_BYTE);
        rx_stream.push_back(8'h05);
        rx_stream.push_back(NUL_BYTE);
        rx_stream.push_back(LEN_EXT1);
        rx_stream.push_back(8'h06);
        rx_stream.push_back(STX_BYTE);
        rx_stream.push_back(LEN_EXT2);
        rx_stream.push_back(8'h00);
        rx_stream.push_back(8'h05);
        // missing etx together with a bad lrc
        rx_stream.push_back(STX_BYTE);
        rx_stream.push_back(8'h06);
        rx_stream.push_back(8'h00);
        rx_stream.push_back(8'h5A);
        rx_stream.push_back(8'hA1);
        rx_stream.push_back(8'h7E);

        while (rx_stream.size() < ITEMS) begin
            pick  = $urandom_range(0, 99);
            start = $urandom_range(0, 1) ? STX_BYTE : NUL_BYTE;
            form  = $urandom_range(0, 99);
            form  = form < 60 ? 1 : (form < 85 ? 2 : 3);
            max_data = form == 1 ? 121 : (form == 2 ? 248 : 392);
            n_data = ($urandom_range(0, 29) == 0) ? $urandom_range(0, max_data)
                                                   : $urandom_range(0, 12);
            if (pick < 70) begin
                push_frame(start, form, n_data, FAULT_NONE);
            end else if (pick < 90) begin
                fault = t_frame_fault'($urandom_range(1, 4));
                push_frame(start, form, n_data, fault);
            end else begin
                repeat ($urandom_range(1, 8))
                    rx_stream.push_back(BYTE_W'($urandom_range(0, 255)));
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (rx_stream[i]) send_request(rx_stream[i]);
        i_valid  <= 1'b0;
        draining = 1'b1;

        while (frames.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (frames.mismatches == 0 && frames.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
